@@ hdl/ptc_pkg.sv @@
// Shared types, codes and constants for the pressure/temperature compensation pipeline.
// No dependencies; every other file in hdl/ imports this package.
package ptc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Arithmetic constants
  localparam logic [19:0] SKIP_MARK   = 20'h80000;
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] DEN_BIAS    = 64'h0000_8000_0000_0000;

  // Pipeline taps, counted in stages after the temperature front end
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned TAP_NUM   = 5;
  localparam int unsigned TAP_DZ    = 10;
  localparam int unsigned CTX_LAST  = 81;
  localparam int unsigned VLD_LAST  = 82;
  // Accepting edge to the edge that samples the result strobe
  localparam int unsigned LATENCY   = 87;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temp;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        pressure_pascal;
    logic [1:0]         status;
  } ptc_out_t;

  // Per-item side information travelling alongside the arithmetic
  typedef struct packed {
    logic        skip;
    logic        den_zero;
    logic [19:0] raw_p;
    logic [31:0] temp;
  } ptc_ctx_t;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

@@ hdl/ptc_mul64.sv @@
// Two-stage 64x64 multiplier giving the low 64 bits of the product (wraps mod 2^64).
// Uses ptc_pkg only by convention; built from three 32x32 partial products.
module ptc_mul64
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q, ll_d;
  logic [31:0] lh_q, lh_d, hl_q, hl_d;
  logic [63:0] p_q, p_d;

  // partial products
  always_comb begin
    ll_d = {32'd0, a_i[31:0]} * {32'd0, b_i[31:0]};
    lh_d = a_i[31:0] * b_i[63:32];
    hl_d = a_i[63:32] * b_i[31:0];
  end

  // recombine
  assign p_d = ll_q + {lh_q + hl_q, 32'd0};

  always_ff @(posedge clk_i) begin
    ll_q <= ll_d;
    lh_q <= lh_d;
    hl_q <= hl_d;
    p_q  <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ hdl/ptc_temp.sv @@
// Temperature front end: five stages from raw samples to centi-degrees and the fine offset.
// Depends on ptc_pkg for the item and side-information types.
module ptc_temp
  import ptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  ptc_in_t          in_i,
  input  logic [CFG_W-1:0] coeffs_i,
  output logic             vld_o,
  output ptc_ctx_t         ctx_o,
  output logic [63:0]      fine_a_o
);

  logic [31:0] t1, t2, t3;
  logic [5:1]  vld_q;
  ptc_ctx_t    ctx_q [1:5];
  logic [31:0] x1_q, dt_q, m1_q, dd_q, v1_q, m2_q, tf_q;
  logic [31:0] x1_d, dt_d, m1_d, dd_d, v1_d, m2_d, tf_d, temp_d;
  logic [63:0] a_q, a_d;
  ptc_ctx_t    ctx1_d, ctx5_d;

  assign t1 = {16'd0, coeffs_i[15:0]};
  assign t2 = {{16{coeffs_i[31]}}, coeffs_i[31:16]};
  assign t3 = {{16{coeffs_i[47]}}, coeffs_i[47:32]};

  // stage logic, int32 wrap throughout but for the 64-bit fine offset
  always_comb begin
    ctx1_d          = '0;
    ctx1_d.skip     = (in_i.raw_pressure == SKIP_MARK) || (in_i.raw_temp == SKIP_MARK);
    ctx1_d.raw_p    = in_i.raw_pressure;
    x1_d   = {15'd0, in_i.raw_temp[19:3]} - {t1[30:0], 1'b0};
    dt_d   = {16'd0, in_i.raw_temp[19:4]} - t1;
    m1_d   = x1_q * t2;
    dd_d   = dt_q * dt_q;
    v1_d   = $signed(m1_q) >>> 11;
    m2_d   = 32'($signed(dd_q) >>> 12) * t3;
    tf_d   = v1_q + 32'($signed(m2_q) >>> 14);
    temp_d = $signed((tf_q << 2) + tf_q + 32'd128) >>> 8;
    a_d    = {{32{tf_q[31]}}, tf_q} - FINE_OFFSET;
    ctx5_d      = ctx_q[4];
    ctx5_d.temp = temp_d;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:1], vld_i};
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ctx_q[1] <= ctx1_d;
    ctx_q[2] <= ctx_q[1];
    ctx_q[3] <= ctx_q[2];
    ctx_q[4] <= ctx_q[3];
    ctx_q[5] <= ctx5_d;
    x1_q <= x1_d;
    dt_q <= dt_d;
    m1_q <= m1_d;
    dd_q <= dd_d;
    v1_q <= v1_d;
    m2_q <= m2_d;
    tf_q <= tf_d;
    a_q  <= a_d;
  end

  assign vld_o    = vld_q[5];
  assign ctx_o    = ctx_q[5];
  assign fine_a_o = a_q;

endmodule

@@ hdl/ptc_div.sv @@
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
// Depends on ptc_pkg for DIV_STEPS; magnitudes are registered before the steps, the sign is restored after them.
module ptc_div
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o
);

  logic [63:0] r_q   [0:DIV_STEPS];
  logic [63:0] nq_q  [0:DIV_STEPS];
  logic [63:0] d_q   [0:DIV_STEPS];
  logic        neg_q [0:DIV_STEPS];
  logic [63:0] quo_q;

  // magnitudes and result sign
  always_ff @(posedge clk_i) begin
    r_q[0]   <= '0;
    nq_q[0]  <= num_i[63] ? (64'd0 - num_i) : num_i;
    d_q[0]   <= den_i[63] ? (64'd0 - den_i) : den_i;
    neg_q[0] <= num_i[63] ^ den_i[63];
  end

  // restoring steps, most significant quotient bit first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [64:0] sh, df;
    assign sh = {r_q[i], nq_q[i][63]};
    assign df = sh - {1'b0, d_q[i]};
    always_ff @(posedge clk_i) begin
      if (!df[64]) begin
        r_q[i+1]  <= df[63:0];
        nq_q[i+1] <= {nq_q[i][62:0], 1'b1};
      end else begin
        r_q[i+1]  <= sh[63:0];
        nq_q[i+1] <= {nq_q[i][62:0], 1'b0};
      end
      d_q[i+1]   <= d_q[i];
      neg_q[i+1] <= neg_q[i];
    end
  end

  // restore sign
  always_ff @(posedge clk_i) begin
    quo_q <= neg_q[DIV_STEPS] ? (64'd0 - nq_q[DIV_STEPS]) : nq_q[DIV_STEPS];
  end

  assign quo_o = quo_q;

endmodule

@@ hdl/pressure_temperature_compensation.sv @@
// Throughput: one item per cycle; busy is never raised, the pipeline advances every cycle.
// Depth is set by the 64-stage divider plus five two-stage 64-bit multiply groups.
// Reset (rst_ni, asynchronous, active low) clears all valid bits and the coefficient
// registers; results leave as one-cycle strobes that the receiver cannot stall.
module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ptc_in_t              in_i,
  output logic                 done_o,
  output ptc_out_t             out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [CFG_W-1:0] tc_q, pa_q, pb_q, pc_q;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic        t_vld;
  ptc_ctx_t    t_ctx;
  logic [63:0] t_a;

  logic [VLD_LAST:1] vld_q;
  ptc_ctx_t    ctx_q [1:CTX_LAST];
  ptc_ctx_t    dz_ctx_d;

  logic [63:0] aa, ap5, ap2, b6, d3, den_m, num_m, quo, m9, m8, m99;
  logic [63:0] ap5_q [1:2];
  logic [63:0] ap2_q [1:2];
  logic [63:0] b_q, den0_q, num0_q, den1_q, den_q, num_q;
  logic [63:0] pr_q [1:4];
  logic [63:0] m8_q [1:2];
  logic [63:0] s_q, pr3_q;
  logic [63:0] b_d, den0_d, num0_d, s_d, pr3_d;
  ptc_out_t    out_q, out_d;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP:    tc_q <= cfg_data_i;
        REG_PRESS_A: pa_q <= cfg_data_i;
        REG_PRESS_B: pb_q <= cfg_data_i;
        REG_PRESS_C: pc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coefficient fields
  assign p1 = {48'd0, pa_q[15:0]};
  assign p2 = sext16(pa_q[31:16]);
  assign p3 = sext16(pa_q[47:32]);
  assign p4 = sext16(pb_q[15:0]);
  assign p5 = sext16(pb_q[31:16]);
  assign p6 = sext16(pb_q[47:32]);
  assign p7 = sext16(pc_q[15:0]);
  assign p8 = sext16(pc_q[31:16]);
  assign p9 = sext16(pc_q[47:32]);

  ptc_temp u_temp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (start && !busy),
    .in_i     (in_i),
    .coeffs_i (tc_q),
    .vld_o    (t_vld),
    .ctx_o    (t_ctx),
    .fine_a_o (t_a)
  );

  // a*a, a*p5, a*p2
  ptc_mul64 u_aa  (.clk_i(clk_i), .a_i(t_a), .b_i(t_a), .p_o(aa));
  ptc_mul64 u_ap5 (.clk_i(clk_i), .a_i(t_a), .b_i(p5),  .p_o(ap5));
  ptc_mul64 u_ap2 (.clk_i(clk_i), .a_i(t_a), .b_i(p2),  .p_o(ap2));

  // a*a*p6, a*a*p3
  ptc_mul64 u_b6 (.clk_i(clk_i), .a_i(aa), .b_i(p6), .p_o(b6));
  ptc_mul64 u_d3 (.clk_i(clk_i), .a_i(aa), .b_i(p3), .p_o(d3));

  // offset sums, numerator and biased divisor
  always_comb begin
    b_d    = b6 + (ap5_q[2] << 17) + (p4 << 35);
    den0_d = 64'($signed(d3) >>> 8) + (ap2_q[2] << 12);
    num0_d = ((PRESS_BASE - {44'd0, ctx_q[TAP_NUM].raw_p}) << 31) - b_q;
  end

  ptc_mul64 u_den (.clk_i(clk_i), .a_i(den1_q), .b_i(p1),          .p_o(den_m));
  ptc_mul64 u_num (.clk_i(clk_i), .a_i(num0_q), .b_i(PRESS_SCALE), .p_o(num_m));

  ptc_div u_div (.clk_i(clk_i), .num_i(num_q), .den_i(den_q), .quo_o(quo));

  // p9*q, p8*pr, then (p9*q)*q
  ptc_mul64 u_m9  (.clk_i(clk_i), .a_i(p9), .b_i(64'($signed(quo) >>> 13)), .p_o(m9));
  ptc_mul64 u_m8  (.clk_i(clk_i), .a_i(p8), .b_i(quo), .p_o(m8));
  ptc_mul64 u_m99 (.clk_i(clk_i), .a_i(m9), .b_i(64'($signed(pr_q[2]) >>> 13)), .p_o(m99));

  // final correction and result
  always_comb begin
    s_d   = pr_q[4] + 64'($signed(m99) >>> 25) + 64'($signed(m8_q[2]) >>> 19);
    pr3_d = 64'($signed(s_q) >>> 8) + (p7 << 4);
    out_d = '0;
    if (ctx_q[CTX_LAST].skip) begin
      out_d.status = ST_SKIP;
    end else if (ctx_q[CTX_LAST].den_zero) begin
      out_d.temp_centi = ctx_q[CTX_LAST].temp;
      out_d.status     = ST_ERR;
    end else begin
      out_d.temp_centi      = ctx_q[CTX_LAST].temp;
      out_d.pressure_pascal = pr3_q[39:8];
      out_d.status          = (pr3_q[39:8] == 32'd0) ? ST_ERR : ST_OK;
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_LAST-1:1], t_vld};
    end
  end

  // divisor check joins the side line after the scaling stage
  always_comb begin
    dz_ctx_d          = ctx_q[TAP_DZ-1];
    dz_ctx_d.den_zero = (den_q == 64'd0);
  end

  // side information line
  always_ff @(posedge clk_i) begin
    ctx_q[1] <= t_ctx;
    for (int k = 2; k <= CTX_LAST; k++) begin
      ctx_q[k] <= (k == TAP_DZ) ? dz_ctx_d : ctx_q[k-1];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ap5_q[1] <= ap5;
    ap5_q[2] <= ap5_q[1];
    ap2_q[1] <= ap2;
    ap2_q[2] <= ap2_q[1];
    b_q      <= b_d;
    den0_q   <= den0_d;
    num0_q   <= num0_d;
    den1_q   <= DEN_BIAS + den0_q;
    den_q    <= 64'($signed(den_m) >>> 33);
    num_q    <= num_m;
    pr_q[1]  <= quo;
    pr_q[2]  <= pr_q[1];
    pr_q[3]  <= pr_q[2];
    pr_q[4]  <= pr_q[3];
    m8_q[1]  <= m8;
    m8_q[2]  <= m8_q[1];
    s_q      <= s_d;
    pr3_q    <= pr3_d;
    out_q    <= out_d;
  end

  assign done_o = vld_q[VLD_LAST];
  assign out_o  = out_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted item did not produce a result at the expected cycle");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.status == ST_SKIP) |->
      (out_o.pressure_pascal == 32'd0 && out_o.temp_centi == 32'sd0))
    else $error("skipped sample result carries nonzero fields");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.status == ST_OK) |-> (out_o.pressure_pascal != 32'd0))
    else $error("ok status with zero pressure");
`endif

endmodule

@@ tb/sv/ptc_checker.sv @@
// Scoreboard for the pressure/temperature compensation block: watches the command,
// configuration and result ports, predicts each result and compares it field by field.
// Depends on ptc_pkg for the port types, register indexes and status codes.
`timescale 1ns / 1ps

module ptc_checker
  import ptc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  ptc_in_t              in_i,
  input  logic                 done_i,
  input  ptc_out_t             out_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  logic [47:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  ptc_out_t    expected_q[$];
  int          errors = 0;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic logic [31:0] sra32(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed 64-bit quotient truncated toward zero; min / -1 wraps to min
  function automatic logic [63:0] quot64(logic [63:0] n, logic [63:0] d);
    logic [63:0] un, ud, uq;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    uq = un / ud;
    return (n[63] != d[63]) ? -uq : uq;
  endfunction

  // Integer compensation of one sample pair with the current coefficients
  function automatic ptc_out_t compensate(ptc_in_t x);
    ptc_out_t    r;
    logic [31:0] at, t1, t2, t3, d, v1, v2, tf, prod;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, den, pr, q;
    r = '0;
    if (x.raw_pressure == SKIP_MARK || x.raw_temp == SKIP_MARK) begin
      r.status = ST_SKIP;
      return r;
    end
    at   = {12'd0, x.raw_temp};
    t1   = {16'd0, temp_cal[15:0]};
    t2   = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3   = {{16{temp_cal[47]}}, temp_cal[47:32]};
    prod = ((at >> 3) - (t1 << 1)) * t2;
    v1   = sra32(prod, 11);
    d    = (at >> 4) - t1;
    prod = d * d;
    prod = sra32(prod, 12) * t3;
    v2   = sra32(prod, 14);
    tf   = v1 + v2;
    prod = tf * 32'd5 + 32'd128;
    r.temp_centi = sra32(prod, 8);

    p1 = {48'd0, press_cal_a[15:0]};
    p2 = sx16(press_cal_a[31:16]);
    p3 = sx16(press_cal_a[47:32]);
    p4 = sx16(press_cal_b[15:0]);
    p5 = sx16(press_cal_b[31:16]);
    p6 = sx16(press_cal_b[47:32]);
    p7 = sx16(press_cal_c[15:0]);
    p8 = sx16(press_cal_c[31:16]);
    p9 = sx16(press_cal_c[47:32]);

    a   = {{32{tf[31]}}, tf} - 64'd128000;
    b   = a * a * p6;
    b   = b + ((a * p5) << 17);
    b   = b + (p4 << 35);
    den = a * a * p3;
    den = sra64(den, 8) + ((a * p2) << 12);
    den = (64'h0000_8000_0000_0000 + den) * p1;
    den = sra64(den, 33);
    if (den == 64'd0) begin
      r.status = ST_ERR;
      return r;
    end
    pr = 64'd1048576 - {44'd0, x.raw_pressure};
    pr = quot64(((pr << 31) - b) * 64'd3125, den);
    q  = sra64(pr, 13);
    a  = sra64(p9 * q * q, 25);
    b  = sra64(p8 * pr, 19);
    pr = sra64(pr + a + b, 8) + (p7 << 4);
    pr = sra64(pr, 8);
    r.pressure_pascal = pr[31:0];
    r.status = (pr[31:0] == 32'd0) ? ST_ERR : ST_OK;
    return r;
  endfunction

  // Track register writes, queue predictions, check results
  always @(posedge clk_i or negedge rst_ni) begin
    ptc_out_t want;
    if (!rst_ni) begin
      temp_cal    <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TEMP:    temp_cal    <= cfg_data_i;
          REG_PRESS_A: press_cal_a <= cfg_data_i;
          REG_PRESS_B: press_cal_b <= cfg_data_i;
          REG_PRESS_C: press_cal_c <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_q.push_back(compensate(in_i));
      if (done_i) begin
        if (expected_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result: %p", out_i);
        end else begin
          want = expected_q.pop_front();
          if (out_i.temp_centi !== want.temp_centi ||
              out_i.pressure_pascal !== want.pressure_pascal ||
              out_i.status !== want.status) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: temp exp %0d got %0d, press exp %0d got %0d, st exp %0d got %0d",
                       want.temp_centi, out_i.temp_centi, want.pressure_pascal,
                       out_i.pressure_pascal, want.status, out_i.status);
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/pressure_temperature_compensation_tb.sv @@
// Top of the compensation testbench: clock, reset, register setup and sample stimulus.
// Depends on ptc_pkg, the block under test and ptc_checker, which does all checking.
`timescale 1ns / 1ps

module pressure_temperature_compensation_tb;
  import ptc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  ptc_in_t              in_i = '0;
  logic                 done_o;
  ptc_out_t             out_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_TEMP;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  int                   errors, pending, cycles, samples;
  int                   idle_pct;
  logic                 took_q;

  always #1 clk_i = ~clk_i;

  pressure_temperature_compensation dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .done_o, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  ptc_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .in_i, .done_i(done_o), .out_i(out_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  // Transfer flag, sampled with the pre-edge values
  always @(posedge clk_i) took_q <= start && !busy;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stop sending, drain the pipeline, then allow for its latency
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic set_coeffs(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc);
    logic [47:0] words[4];
    words = '{tc, pa, pb, pc};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[CFG_IDX_W-1:0];
      cfg_data_i <= words[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // One sample transfer, with an optional idle gap afterwards
  task automatic send(logic [19:0] rp, logic [19:0] rt);
    start <= 1'b1;
    in_i  <= '{raw_pressure: rp, raw_temp: rt};
    do @(negedge clk_i); while (!took_q);
    samples++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_i  <= 40'({$urandom(), $urandom()});
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  function automatic logic [19:0] raw_value(logic [19:0] centre);
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return SKIP_MARK;
    if (pick < 30) return 20'($urandom());
    return 20'(centre + $urandom_range(0, 16383) - 20'd8192);
  endfunction

  // Typical coefficients, optionally jittered
  function automatic logic [191:0] typical_set(bit jitter);
    logic [15:0] c[12];
    c = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
          16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
    if (jitter) foreach (c[i]) c[i] = 16'(c[i] + $urandom_range(0, 63) - 16'd32);
    return {c[11], c[10], c[9], c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
  endfunction

  initial begin
    logic [191:0] cal;
    samples = 0;
    idle_pct = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset coefficients: divisor is zero
    send(20'd415148, 20'd519888);
    send(20'h80000, 20'd519888);
    settle();

    // Typical coefficients: extremes, skip markers, nominal point
    cal = typical_set(0);
    set_coeffs(cal[47:0], cal[95:48], cal[143:96], cal[191:144]);
    send(20'd415148, 20'd519888);
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'd0);
    send(20'h80000, 20'd0);
    send(20'd0, 20'h80000);
    send(20'h80000, 20'h80000);
    send(20'h7FFFF, 20'h80001);
    send(20'd1048575, 20'd519888);
    settle();

    // p1 zero gives a zero divisor with a live temperature
    set_coeffs(cal[47:0], {cal[95:64], 16'd0}, cal[143:96], cal[191:144]);
    send(20'd415148, 20'd519888);
    send(20'hFFFFF, 20'd1);
    settle();

    // All ones and most positive coefficients
    set_coeffs('1, '1, '1, '1);
    send(20'd415148, 20'd519888);
    send(20'd0, 20'hFFFFF);
    settle();
    set_coeffs({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    settle();
    // Most negative coefficients
    set_coeffs({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send(20'd12345, 20'd67890);
    send(20'hFFFFF, 20'hFFFFF);
    settle();

    // Random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 58;
        2: idle_pct = 8;
        default: idle_pct = $urandom_range(0, 30);
      endcase
      if (ph % 3 == 2)
        cal = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      else
        cal = typical_set(1);
      set_coeffs(cal[47:0], cal[95:48], cal[143:96], cal[191:144]);
      repeat (135) send(raw_value(20'd415148), raw_value(20'd519888));
      settle();
    end

    $display("%0d samples over reset, extreme, typical and random coefficient sets", samples);
    $display("with sender idle rates of 0, 8 and 58 percent; %0d mismatches", errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
